// ===== design/lwa_pkg.sv =====
package lwa_pkg;

  localparam int unsigned AccBits    = 64;
  localparam int unsigned CountBits  = 16;
  localparam int unsigned TargetBits = 16;
  localparam int unsigned CharBits   = 8;
  localparam int unsigned LenBits    = $clog2(AccBits + 1);
  localparam int unsigned CmpBits    = (CountBits > TargetBits) ? CountBits : TargetBits;

  localparam logic [CharBits-1:0] ChUnder = 8'h5f;
  localparam logic [CharBits-1:0] ChZero  = 8'h30;
  localparam logic [CharBits-1:0] ChNine  = 8'h39;
  localparam logic [CharBits-1:0] ChLowA  = 8'h61;
  localparam logic [CharBits-1:0] ChLowF  = 8'h66;
  localparam logic [CharBits-1:0] ChUpA   = 8'h41;
  localparam logic [CharBits-1:0] ChUpF   = 8'h46;
  localparam logic [CharBits-1:0] ChLowX  = 8'h78;
  localparam logic [CharBits-1:0] ChUpX   = 8'h58;
  localparam logic [CharBits-1:0] ChLowZ  = 8'h7a;
  localparam logic [CharBits-1:0] ChUpZ   = 8'h5a;

  typedef enum logic [1:0] {
    RADIX_BIN,
    RADIX_HEX,
    RADIX_DEC,
    RADIX_BAD
  } radix_e;

  typedef enum logic [1:0] {
    FILL_NONE,
    FILL_ZERO,
    FILL_X,
    FILL_Z
  } fill_e;

  // final counters of one literal, handed from the scanner to the resolver
  typedef struct packed {
    logic                  pre_err;
    radix_e                radix;
    logic [TargetBits-1:0] target;
    fill_e                 lead_class;
    logic                  seen_digit;
    logic [CountBits-1:0]  digit_count;
    logic                  hex_found;
    logic [2:0]            hex_top_bits;
    logic [CountBits-1:0]  hex_tail_count;
    logic                  dec_overflow;
    logic                  dec_bad;
    logic [AccBits-1:0]    dec_accum;
  } snap_t;

  function automatic logic [CountBits-1:0] sat_inc(input logic [CountBits-1:0] x);
    return (x == {CountBits{1'b1}}) ? x : x + CountBits'(1);
  endfunction

  // non-hex characters read as a zero nibble
  function automatic logic [3:0] nibble_val(input logic [CharBits-1:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= ChZero && c <= ChNine) begin
      v = c[3:0];
    end else if ((c >= ChLowA && c <= ChLowF) || (c >= ChUpA && c <= ChUpF)) begin
      v = c[3:0] + 4'd9;
    end
    return v;
  endfunction

  function automatic logic [2:0] top_bit_pos(input logic [3:0] v);
    logic [2:0] p;
    if (v[3]) begin
      p = 3'd4;
    end else if (v[2]) begin
      p = 3'd3;
    end else if (v[1]) begin
      p = 3'd2;
    end else begin
      p = 3'd1;
    end
    return p;
  endfunction

endpackage

// ===== design/lwa_scan.sv =====
module lwa_scan (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  lwa_pkg::radix_e                 in_radix_i,
  input  logic [lwa_pkg::TargetBits-1:0]  in_target_i,
  input  logic                            in_has_char_i,
  input  logic [lwa_pkg::CharBits-1:0]    in_char_i,
  input  logic                            in_end_i,
  output logic                            snap_valid_o,
  input  logic                            snap_ready_i,
  output lwa_pkg::snap_t                  snap_o
);

  // input register
  logic                           a_vld_q;
  lwa_pkg::radix_e                a_radix_q;
  logic [lwa_pkg::TargetBits-1:0] a_target_q;
  logic                           a_has_q;
  logic [lwa_pkg::CharBits-1:0]   a_char_q;
  logic                           a_end_q;
  logic                           a_fire;

  // literal state
  logic                           seen_digit_q, seen_digit_d;
  lwa_pkg::fill_e                 lead_class_q, lead_class_d;
  logic [lwa_pkg::CountBits-1:0]  digit_count_q, digit_count_d;
  logic [lwa_pkg::AccBits-1:0]    dec_accum_q, dec_accum_d;
  logic                           dec_overflow_q, dec_overflow_d;
  logic                           dec_bad_q, dec_bad_d;
  logic                           hex_found_q, hex_found_d;
  logic [2:0]                     hex_top_bits_q, hex_top_bits_d;
  logic [lwa_pkg::CountBits-1:0]  hex_tail_count_q, hex_tail_count_d;
  logic                           any_char_q, any_char_d;

  logic                           take;
  logic                           is_digit;
  logic [3:0]                     nib;
  logic [lwa_pkg::AccBits+3:0]    acc_ext;
  logic [lwa_pkg::AccBits+3:0]    acc_next;

  assign a_fire     = a_vld_q & (~a_end_q | snap_ready_i);
  assign in_ready_o = ~a_vld_q | a_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      a_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      a_radix_q  <= in_radix_i;
      a_target_q <= in_target_i;
      a_has_q    <= in_has_char_i;
      a_char_q   <= in_char_i;
      a_end_q    <= in_end_i;
    end
  end

  assign take     = a_has_q & (a_char_q != lwa_pkg::ChUnder);
  assign is_digit = (a_char_q >= lwa_pkg::ChZero) && (a_char_q <= lwa_pkg::ChNine);
  assign nib      = lwa_pkg::nibble_val(a_char_q);
  assign acc_ext  = {4'b0000, dec_accum_q};
  // times ten plus digit; anything above the accumulator width is an overflow
  assign acc_next = (acc_ext << 3) + (acc_ext << 1) + (lwa_pkg::AccBits + 4)'(a_char_q[3:0]);

  always_comb begin
    seen_digit_d     = seen_digit_q;
    lead_class_d     = lead_class_q;
    digit_count_d    = digit_count_q;
    dec_accum_d      = dec_accum_q;
    dec_overflow_d   = dec_overflow_q;
    dec_bad_d        = dec_bad_q;
    hex_found_d      = hex_found_q;
    hex_top_bits_d   = hex_top_bits_q;
    hex_tail_count_d = hex_tail_count_q;
    any_char_d       = any_char_q | a_has_q;
    if (take) begin
      if (!seen_digit_q) begin
        seen_digit_d = 1'b1;
        if (a_char_q == lwa_pkg::ChLowX || a_char_q == lwa_pkg::ChUpX) begin
          lead_class_d = lwa_pkg::FILL_X;
        end else if (a_char_q == lwa_pkg::ChLowZ || a_char_q == lwa_pkg::ChUpZ) begin
          lead_class_d = lwa_pkg::FILL_Z;
        end else begin
          lead_class_d = lwa_pkg::FILL_ZERO;
        end
      end
      digit_count_d = lwa_pkg::sat_inc(digit_count_q);
      if (hex_found_q) begin
        hex_tail_count_d = lwa_pkg::sat_inc(hex_tail_count_q);
      end else if (nib != 4'd0) begin
        hex_found_d    = 1'b1;
        hex_top_bits_d = lwa_pkg::top_bit_pos(nib);
      end
      if (!dec_overflow_q && !dec_bad_q) begin
        if (!is_digit) begin
          dec_bad_d = 1'b1;
        end else if (acc_next[lwa_pkg::AccBits+3:lwa_pkg::AccBits] != 4'd0) begin
          dec_overflow_d = 1'b1;
        end else begin
          dec_accum_d = acc_next[lwa_pkg::AccBits-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_digit_q     <= 1'b0;
      lead_class_q     <= lwa_pkg::FILL_ZERO;
      digit_count_q    <= '0;
      dec_accum_q      <= '0;
      dec_overflow_q   <= 1'b0;
      dec_bad_q        <= 1'b0;
      hex_found_q      <= 1'b0;
      hex_top_bits_q   <= '0;
      hex_tail_count_q <= '0;
      any_char_q       <= 1'b0;
    end else if (a_fire) begin
      if (a_end_q) begin
        seen_digit_q     <= 1'b0;
        lead_class_q     <= lwa_pkg::FILL_ZERO;
        digit_count_q    <= '0;
        dec_accum_q      <= '0;
        dec_overflow_q   <= 1'b0;
        dec_bad_q        <= 1'b0;
        hex_found_q      <= 1'b0;
        hex_top_bits_q   <= '0;
        hex_tail_count_q <= '0;
        any_char_q       <= 1'b0;
      end else begin
        seen_digit_q     <= seen_digit_d;
        lead_class_q     <= lead_class_d;
        digit_count_q    <= digit_count_d;
        dec_accum_q      <= dec_accum_d;
        dec_overflow_q   <= dec_overflow_d;
        dec_bad_q        <= dec_bad_d;
        hex_found_q      <= hex_found_d;
        hex_top_bits_q   <= hex_top_bits_d;
        hex_tail_count_q <= hex_tail_count_d;
        any_char_q       <= any_char_d;
      end
    end
  end

  assign snap_valid_o = a_vld_q & a_end_q;

  always_comb begin
    snap_o.pre_err        = ~any_char_d | (a_target_q == '0) | (a_radix_q == lwa_pkg::RADIX_BAD);
    snap_o.radix          = a_radix_q;
    snap_o.target         = a_target_q;
    snap_o.lead_class     = lead_class_d;
    snap_o.seen_digit     = seen_digit_d;
    snap_o.digit_count    = digit_count_d;
    snap_o.hex_found      = hex_found_d;
    snap_o.hex_top_bits   = hex_top_bits_d;
    snap_o.hex_tail_count = hex_tail_count_d;
    snap_o.dec_overflow   = dec_overflow_d;
    snap_o.dec_bad        = dec_bad_d;
    snap_o.dec_accum      = dec_accum_d;
  end

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_fire && a_end_q |=> !any_char_q && !seen_digit_q && digit_count_q == '0)
    else $error("literal state not cleared after end beat");

  tail_below_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hex_tail_count_q <= digit_count_q)
    else $error("hex tail count ahead of digit count");

  no_digit_no_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !seen_digit_q |-> digit_count_q == '0 && !hex_found_q)
    else $error("digits counted before first digit");

endmodule

// ===== design/lwa_resolve.sv =====
module lwa_resolve (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           snap_valid_i,
  output logic                           snap_ready_o,
  input  lwa_pkg::snap_t                 snap_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           out_error_o,
  output logic [lwa_pkg::TargetBits-1:0] out_width_o,
  output lwa_pkg::fill_e                 out_fill_o
);

  logic                           b_vld_q;
  lwa_pkg::snap_t                 b_q;
  logic                           o_vld_q;
  logic                           o_err_q;
  logic [lwa_pkg::TargetBits-1:0] o_width_q;
  lwa_pkg::fill_e                 o_fill_q;
  logic                           o_take;

  logic [lwa_pkg::LenBits-1:0]    dec_len;
  logic [lwa_pkg::CountBits+2:0]  hex_sum;
  logic [lwa_pkg::CountBits-1:0]  hex_width;
  logic [lwa_pkg::CountBits-1:0]  width;
  logic [lwa_pkg::CmpBits-1:0]    wide;
  logic [lwa_pkg::CmpBits-1:0]    tgt;
  logic                           err;
  lwa_pkg::fill_e                 fill;

  assign o_take       = ~o_vld_q | out_ready_i;
  assign snap_ready_o = ~b_vld_q | o_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (snap_ready_o) begin
      b_vld_q <= snap_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (snap_valid_i && snap_ready_o) begin
      b_q <= snap_i;
    end
  end

  // bit length: each bit checks that nothing above it is set
  always_comb begin
    dec_len = '0;
    for (int i = 0; i < lwa_pkg::AccBits; i++) begin
      if (b_q.dec_accum[i] && ((b_q.dec_accum >> (i + 1)) == '0)) begin
        dec_len = dec_len | lwa_pkg::LenBits'(i + 1);
      end
    end
  end

  assign hex_sum   = {1'b0, b_q.hex_tail_count, 2'b00} + (lwa_pkg::CountBits + 3)'(b_q.hex_top_bits);
  assign hex_width = (hex_sum[lwa_pkg::CountBits+2:lwa_pkg::CountBits] != 3'd0)
                   ? {lwa_pkg::CountBits{1'b1}} : hex_sum[lwa_pkg::CountBits-1:0];

  always_comb begin
    err   = 1'b0;
    width = '0;
    fill  = lwa_pkg::FILL_ZERO;
    case (b_q.radix)
      lwa_pkg::RADIX_BIN: begin
        width = b_q.digit_count;
        fill  = b_q.lead_class;
      end
      lwa_pkg::RADIX_HEX: begin
        if (!b_q.seen_digit) begin
          err = 1'b1;
        end else if (!b_q.hex_found) begin
          width = lwa_pkg::CountBits'(1);
        end else begin
          width = hex_width;
        end
      end
      lwa_pkg::RADIX_DEC: begin
        if (b_q.dec_overflow) begin
          width = lwa_pkg::CountBits'(lwa_pkg::AccBits);
        end else if (b_q.dec_bad) begin
          err = 1'b1;
        end else if (b_q.dec_accum == '0) begin
          width = lwa_pkg::CountBits'(1);
        end else begin
          width = lwa_pkg::CountBits'(dec_len);
        end
      end
      default: begin
        err = 1'b1;
      end
    endcase
    if (b_q.pre_err) begin
      err = 1'b1;
    end
    wide = lwa_pkg::CmpBits'(width);
    tgt  = lwa_pkg::CmpBits'(b_q.target);
    if (!err && wide > tgt) begin
      err = 1'b1;
    end
    if (!err && wide == tgt) begin
      fill = lwa_pkg::FILL_NONE;
    end
    if (err) begin
      wide = '0;
      fill = lwa_pkg::FILL_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_vld_q <= 1'b0;
    end else if (o_take) begin
      o_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_vld_q && o_take) begin
      o_err_q   <= err;
      o_width_q <= wide[lwa_pkg::TargetBits-1:0];
      o_fill_q  <= fill;
    end
  end

  assign out_valid_o = o_vld_q;
  assign out_error_o = o_err_q;
  assign out_width_o = o_width_q;
  assign out_fill_o  = o_fill_q;

  snap_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_vld_q && !o_take |=> b_vld_q && $stable(b_q))
    else $error("pending literal lost while output stalled");

  err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    o_vld_q && o_err_q |-> o_width_q == '0 && o_fill_q == lwa_pkg::FILL_NONE)
    else $error("rejected literal carries width or fill");

endmodule

// ===== design/literal_width_analyzer.sv =====
// Literal width analyzer. Feed the characters of one numeric literal, one per beat, with
// tlast on the final beat (radix and target width are taken from that beat); a beat with
// has_char low and tlast low is ignored. After the final beat one result beat follows
// by way of the snapshot and output registers. A new beat is accepted every cycle unless a
// final beat waits on a stalled result path; the character state updates (64-bit
// times-ten-plus-digit add, saturating 16-bit counters), then a snapshot register feeds the
// width resolution (64-bit leading-one search, target compare) into the output register.
module literal_width_analyzer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // target_width[15:0], char_code[23:16]
  input  logic [2:0]  s_axis_tuser_i,   // radix[1:0], has_char[2]
  input  logic        s_axis_tlast_i,   // end_of_literal
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // natural_width[15:0], fill_kind[17:16], zeros above
  output logic        m_axis_tuser_o    // error_flag
);

  logic                           snap_valid;
  logic                           snap_ready;
  lwa_pkg::snap_t                 snap;
  logic [lwa_pkg::TargetBits-1:0] out_width;
  lwa_pkg::fill_e                 out_fill;

  lwa_scan u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid_i),
    .in_ready_o    (s_axis_tready_o),
    .in_radix_i    (lwa_pkg::radix_e'(s_axis_tuser_i[1:0])),
    .in_target_i   (s_axis_tdata_i[15:0]),
    .in_has_char_i (s_axis_tuser_i[2]),
    .in_char_i     (s_axis_tdata_i[23:16]),
    .in_end_i      (s_axis_tlast_i),
    .snap_valid_o  (snap_valid),
    .snap_ready_i  (snap_ready),
    .snap_o        (snap)
  );

  lwa_resolve u_resolve (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .snap_valid_i (snap_valid),
    .snap_ready_o (snap_ready),
    .snap_i       (snap),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_error_o  (m_axis_tuser_o),
    .out_width_o  (out_width),
    .out_fill_o   (out_fill)
  );

  assign m_axis_tdata_o = {6'b000000, out_fill, out_width};

endmodule
